// ===== rtl/core/s256p_pkg.sv =====
`timescale 1ns / 1ps

package s256p_pkg;

  localparam int COUNT_W = 61;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_FINAL = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [3:0] IDX_BEFORE_LEN = 4'd13;
  localparam logic [3:0] IDX_BLOCK_END  = 4'd15;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } src_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic        end_of_block;
    logic        last;
  } dst_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic emit_pad;
    logic emit_zero;
    logic emit_hi;
    logic emit_lo;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic count_idx13;
    logic widx13;
  } status_t;

endpackage

// ===== rtl/core/s256p_datapath.sv =====
`timescale 1ns / 1ps

module s256p_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  s256p_pkg::cmd_t      cmd,
  output s256p_pkg::status_t   status,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output s256p_pkg::dst_beat_t dst_data
);

  logic [s256p_pkg::COUNT_W-1:0] byte_count;
  logic [23:0]                   partial_word;
  logic [3:0]                    widx;
  logic                          word_done;
  logic                          load;
  logic [31:0]                   pad_word;
  s256p_pkg::dst_beat_t          beat_next;

  assign word_done = cmd.take_byte && (byte_count[1:0] == 2'd3);
  assign load = word_done || cmd.emit_pad || cmd.emit_zero || cmd.emit_hi || cmd.emit_lo;

  assign status.out_free    = !dst_valid || dst_ready;
  assign status.count_idx13 = (byte_count[5:2] == s256p_pkg::IDX_BEFORE_LEN);
  assign status.widx13      = (widx == s256p_pkg::IDX_BEFORE_LEN);

  always_comb begin
    case (byte_count[1:0])
      2'd0:    pad_word = {s256p_pkg::PAD_MARK, 24'h000000};
      2'd1:    pad_word = {partial_word[7:0], s256p_pkg::PAD_MARK, 16'h0000};
      2'd2:    pad_word = {partial_word[15:0], s256p_pkg::PAD_MARK, 8'h00};
      default: pad_word = {partial_word[23:0], s256p_pkg::PAD_MARK};
    endcase
  end

  always_comb begin
    beat_next = '0;
    if (cmd.take_byte) begin
      beat_next.word         = {partial_word, data_byte};
      beat_next.end_of_block = (byte_count[5:0] == 6'd63);
    end else if (cmd.emit_pad) begin
      beat_next.word         = pad_word;
      beat_next.end_of_block = (byte_count[5:2] == s256p_pkg::IDX_BLOCK_END);
    end else if (cmd.emit_zero) begin
      beat_next.end_of_block = (widx == s256p_pkg::IDX_BLOCK_END);
    end else if (cmd.emit_hi) begin
      beat_next.word         = byte_count[60:29];
    end else if (cmd.emit_lo) begin
      beat_next.word         = {byte_count[28:0], 3'b000};
      beat_next.end_of_block = 1'b1;
      beat_next.last         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      partial_word <= '0;
      widx         <= '0;
      dst_valid    <= 1'b0;
    end else begin
      if (load) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
      if (cmd.take_byte) begin
        byte_count   <= byte_count + s256p_pkg::COUNT_W'(1);
        partial_word <= word_done ? 24'h000000 : {partial_word[15:0], data_byte};
      end
      if (cmd.emit_pad) begin
        widx <= byte_count[5:2] + 4'd1;
      end else if (cmd.emit_zero || cmd.emit_hi) begin
        widx <= widx + 4'd1;
      end
      if (cmd.emit_lo) begin
        byte_count   <= '0;
        partial_word <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst_data <= beat_next;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_byte, cmd.emit_pad, cmd.emit_zero, cmd.emit_hi, cmd.emit_lo}))
    else $error("More than one datapath command at once.");
  a_last_ends_block: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.last |-> dst_data.end_of_block)
    else $error("Final word does not close a block.");
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_lo |=> (byte_count == '0) && (partial_word == '0))
    else $error("Message state not cleared after the length word.");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> status.out_free)
    else $error("Output word overwritten before it was taken.");
`endif

endmodule

// ===== rtl/core/s256p_ctrl.sv =====
`timescale 1ns / 1ps

module s256p_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  logic [1:0]         mode,
  input  s256p_pkg::status_t status,
  output s256p_pkg::cmd_t    cmd
);

  s256p_pkg::state_t state;
  s256p_pkg::state_t state_next;
  logic              accept;

  assign accept = src_valid && src_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s256p_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    src_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      s256p_pkg::ST_IDLE: begin
        src_ready = status.out_free;
        if (src_valid && status.out_free) begin
          unique case (mode)
            s256p_pkg::MODE_BYTE: begin
              cmd.take_byte = 1'b1;
            end
            s256p_pkg::MODE_FINAL: begin
              cmd.take_byte = 1'b1;
              state_next    = s256p_pkg::ST_PAD;
            end
            s256p_pkg::MODE_END: begin
              state_next = s256p_pkg::ST_PAD;
            end
            default: begin
            end
          endcase
        end
      end
      s256p_pkg::ST_PAD: begin
        if (status.out_free) begin
          cmd.emit_pad = 1'b1;
          state_next   = status.count_idx13 ? s256p_pkg::ST_LEN_HI : s256p_pkg::ST_ZERO;
        end
      end
      s256p_pkg::ST_ZERO: begin
        if (status.out_free) begin
          cmd.emit_zero = 1'b1;
          state_next    = status.widx13 ? s256p_pkg::ST_LEN_HI : s256p_pkg::ST_ZERO;
        end
      end
      s256p_pkg::ST_LEN_HI: begin
        if (status.out_free) begin
          cmd.emit_hi = 1'b1;
          state_next  = s256p_pkg::ST_LEN_LO;
        end
      end
      s256p_pkg::ST_LEN_LO: begin
        if (status.out_free) begin
          cmd.emit_lo = 1'b1;
          state_next  = s256p_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = s256p_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == s256p_pkg::ST_IDLE))
    else $error("Input beat taken while padding.");
  a_hi_then_lo: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_hi |=> (state == s256p_pkg::ST_LEN_LO))
    else $error("High length word not followed by the low length word.");
`endif

endmodule

// ===== rtl/core/sha256_message_padder.sv =====
`timescale 1ns / 1ps

// Channel  Signals                          Beat
// src      src_valid, src_ready, src_data   mode, data_byte
// dst      dst_valid, dst_ready, dst_data   word, end_of_block, last
//
// Message bytes stream at one per cycle into a single registered output
// word. An end beat is followed by 3 to 18 padding words, one per cycle, and
// no input beat is taken until the last one is loaded. Synchronous reset
// clears the byte count, the partial word and the controller. A stall on dst
// holds the output word and blocks src.

module sha256_message_padder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  s256p_pkg::src_beat_t src_data,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output s256p_pkg::dst_beat_t dst_data
);

  s256p_pkg::cmd_t    cmd;
  s256p_pkg::status_t status;

  s256p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .mode      (src_data.mode),
    .status    (status),
    .cmd       (cmd)
  );

  s256p_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (src_data.data_byte),
    .cmd       (cmd),
    .status    (status),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [5:0] LEN_START = 6'd56;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 src_valid = 1'b0;
  logic                 src_ready;
  s256p_pkg::src_beat_t src_data = '0;
  logic                 dst_valid;
  logic                 dst_ready = 1'b0;
  s256p_pkg::dst_beat_t dst_data;

  s256p_pkg::dst_beat_t pad_words[$];
  logic [60:0]          msg_bytes = '0;
  logic [23:0]          held_bytes = '0;

  int error_count = 0;
  int words_checked = 0;
  int beats_sent = 0;
  int messages_sent = 0;
  int burst_left = 0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_hold = 0;

  always #10 clk = ~clk;

  sha256_message_padder uut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_data(src_data),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_data(dst_data)
  );

  task automatic pack_byte(inout logic [31:0] acc, inout logic [5:0] pos,
                           input logic [7:0] b, input logic is_last);
    s256p_pkg::dst_beat_t w;
    acc = {acc[23:0], b};
    pos = pos + 6'd1;
    if (pos[1:0] == 2'd0) begin
      w.word = acc;
      w.end_of_block = (pos == 6'd0);
      w.last = is_last;
      pad_words = {pad_words, w};
      acc = '0;
    end
  endtask

  task automatic predict_beat(input s256p_pkg::src_beat_t b);
    logic [31:0] acc;
    logic [5:0]  pos;
    logic [63:0] bit_len;
    int          i;
    acc = {8'h00, held_bytes};
    pos = msg_bytes[5:0];
    case (b.mode)
      s256p_pkg::MODE_BYTE: begin
        pack_byte(acc, pos, b.data_byte, 1'b0);
        msg_bytes = msg_bytes + 61'd1;
        held_bytes = acc[23:0];
      end
      s256p_pkg::MODE_FINAL, s256p_pkg::MODE_END: begin
        if (b.mode == s256p_pkg::MODE_FINAL) begin
          pack_byte(acc, pos, b.data_byte, 1'b0);
          msg_bytes = msg_bytes + 61'd1;
        end
        bit_len = {msg_bytes, 3'b000};
        pack_byte(acc, pos, s256p_pkg::PAD_MARK, 1'b0);
        while (pos != LEN_START) pack_byte(acc, pos, 8'h00, 1'b0);
        for (i = 7; i >= 0; i--) pack_byte(acc, pos, bit_len[8*i +: 8], i == 0);
        msg_bytes = '0;
        held_bytes = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_word(input s256p_pkg::dst_beat_t got);
    s256p_pkg::dst_beat_t want;
    if (pad_words.size() == 0) begin
      $error("unexpected word %h (end_of_block %b, last %b)",
             got.word, got.end_of_block, got.last);
      error_count++;
    end else begin
      want = pad_words.pop_front();
      words_checked++;
      if (got.word !== want.word) begin
        $error("word: expected %h, actual %h", want.word, got.word);
        error_count++;
      end
      if (got.end_of_block !== want.end_of_block) begin
        $error("end_of_block: expected %b, actual %b", want.end_of_block, got.end_of_block);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (dst_valid && dst_ready) check_word(dst_data);
      if (src_valid && src_ready) predict_beat(src_data);
    end
  end

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_hold = $urandom_range(16, 200);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      READY_ALWAYS: dst_ready <= 1'b1;
      READY_HALF:   dst_ready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: dst_ready <= ($urandom_range(0, 3) == 0);
      default:      dst_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_beat(input logic [1:0] mode, input logic [7:0] data);
    s256p_pkg::src_beat_t b;
    int                   gap;
    b.mode = mode;
    b.data_byte = data;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_valid <= 1'b1;
    src_data <= b;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    beats_sent++;
  endtask

  // The extra edge lets the monitor take the last accepted beat first.
  task automatic wait_drained();
    src_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pad_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_message(input int len, input logic end_with_byte);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(MODE_UNUSED, 8'($urandom_range(0, 255)));
      if (end_with_byte && i == len - 1) begin
        send_beat(s256p_pkg::MODE_FINAL, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(s256p_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    if (!end_with_byte) send_beat(s256p_pkg::MODE_END, 8'($urandom_range(0, 255)));
    messages_sent++;
  endtask

  task automatic test_empty_message();
    send_beat(s256p_pkg::MODE_END, 8'hFF);
    send_beat(s256p_pkg::MODE_END, 8'h00);
    messages_sent += 2;
  endtask

  task automatic test_unused_mode();
    send_beat(MODE_UNUSED, 8'hFF);
    send_beat(s256p_pkg::MODE_BYTE, 8'h12);
    send_beat(MODE_UNUSED, 8'h00);
    send_beat(s256p_pkg::MODE_FINAL, 8'h34);
    messages_sent++;
  endtask

  task automatic test_short_messages();
    send_beat(s256p_pkg::MODE_FINAL, 8'h00);
    send_beat(s256p_pkg::MODE_FINAL, 8'hFF);
    send_beat(s256p_pkg::MODE_BYTE, 8'hFF);
    send_beat(s256p_pkg::MODE_BYTE, 8'h00);
    send_beat(s256p_pkg::MODE_BYTE, 8'hA5);
    send_beat(s256p_pkg::MODE_END, 8'h5A);
    send_beat(s256p_pkg::MODE_BYTE, 8'h01);
    send_beat(s256p_pkg::MODE_BYTE, 8'h02);
    send_beat(s256p_pkg::MODE_BYTE, 8'h03);
    send_beat(s256p_pkg::MODE_BYTE, 8'h04);
    send_beat(s256p_pkg::MODE_END, 8'hC3);
    messages_sent += 4;
  endtask

  // From 56 bytes the length field moves into a second block; 55 still fits.
  task automatic test_random_messages(input int target);
    int   edge_lens[9] = '{0, 1, 55, 56, 57, 63, 64, 119, 120};
    int   len;
    logic end_with_byte;
    while (beats_sent < target) begin
      if ($urandom_range(0, 3) == 0) len = edge_lens[$urandom_range(0, 8)];
      else len = $urandom_range(0, 40);
      if (len > target - beats_sent) len = target - beats_sent;
      end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      send_message(len, end_with_byte);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_unused_mode();
    test_short_messages();
    wait_drained();
    test_random_messages(225);
    wait_drained();
    test_random_messages(450);
    wait_drained();
    $display("Sent %0d messages in %0d beats, mode 3 beats mixed in.", messages_sent,
             beats_sent);
    $display("Checked %0d padded words under random source gaps and sink stalls.",
             words_checked);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== sha256_message_padder.f =====
rtl/core/s256p_pkg.sv
rtl/core/s256p_datapath.sv
rtl/core/s256p_ctrl.sv
rtl/core/sha256_message_padder.sv
verif/testbench.sv
